>>> hw/rtl/gr_pkg.sv
// ----------------------------------------------------------------------------
// gr_pkg: shared types and constants of the reachability engine
// Graph size, command codes and the control/status bundles passed between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package gr_pkg;

    // graph size
    localparam int NODE_W = 6;
    localparam int NODES  = 1 << NODE_W;
    localparam int SP_W   = NODE_W + 1;

    // command codes of an input item
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic latch_in;    // capture source and destination of the item
        logic adj_rd_in;   // read adjacency row at the item's source
        logic adj_rd_stk;  // read adjacency row at the popped vertex
        logic adj_wr;      // write back the row with the new edge set
        logic clr_graph;   // drop every row of the graph
        logic q_init;      // start a search: visited holds the source only
        logic expand;      // take the unvisited neighbours of the row
        logic push;        // push the lowest pending neighbour
        logic pop;         // read the top of the search stack
        logic res_load;    // load the result register
        logic res_value;   // value loaded into the result register
    } gr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic src_eq_dst;  // incoming source equals incoming destination
        logic hit;         // destination among the unvisited neighbours
        logic pend_empty;  // no neighbour left to push
        logic sp_zero;     // search stack empty
        logic sp_full;     // search stack holds one entry per vertex
        logic slot_free;   // result register can take a new item
    } gr_sts_t;

endpackage

>>> hw/rtl/gr_ctrl.sv
// ----------------------------------------------------------------------------
// gr_ctrl: command sequencer of the reachability engine
// Decodes input items and steps the depth-first search: expand a row,
// push the new neighbours one a cycle, pop the next vertex, deliver result.
// ----------------------------------------------------------------------------
module gr_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     command,
    input  gr_pkg::gr_sts_t sts,
    output gr_pkg::gr_cmd_t cmd,
    output logic           in_stall
);
    import gr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_WR,
        S_EXPAND,
        S_PUSH,
        S_POP_RD,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   found_reg;
    logic   found_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        found_next = found_reg;
        cmd        = '0;
        cmd.res_value = found_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_ADD:
                        begin
                            cmd.latch_in  = 1'b1;
                            cmd.adj_rd_in = 1'b1;
                            state_next    = S_ADD_WR;
                        end
                        CMD_QUERY:
                        begin
                            cmd.latch_in = 1'b1;
                            if (sts.src_eq_dst)
                            begin
                                found_next = 1'b1;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                cmd.q_init    = 1'b1;
                                cmd.adj_rd_in = 1'b1;
                                state_next    = S_EXPAND;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cmd.clr_graph = 1'b1;
                        end
                        default:
                        begin
                            // unused code: item dropped
                        end
                    endcase
                end
            end
            S_ADD_WR:
            begin
                cmd.adj_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_EXPAND:
            begin
                if (sts.hit)
                begin
                    found_next = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.expand = 1'b1;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!sts.pend_empty)
                begin
                    cmd.push = 1'b1;
                end
                else if (sts.sp_zero)
                begin
                    found_next = 1'b0;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POP_RD;
                end
            end
            S_POP_RD:
            begin
                cmd.adj_rd_stk = 1'b1;
                state_next     = S_EXPAND;
            end
            S_RESULT:
            begin
                if (sts.slot_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // new items only between commands
    assign in_stall = (state_reg != S_IDLE);

    // state and found flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

endmodule

>>> hw/rtl/gr_datapath.sv
// ----------------------------------------------------------------------------
// gr_datapath: graph storage and search datapath
// Adjacency row memory with per-row valid bits, visited map, pending
// neighbour vector, search stack memory and the result register.
// ----------------------------------------------------------------------------
module gr_datapath
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [gr_pkg::NODE_W-1:0] src_node,
    input  logic [gr_pkg::NODE_W-1:0] dst_node,
    input  gr_pkg::gr_cmd_t           cmd,
    output gr_pkg::gr_sts_t           sts,
    input  logic                      out_stall,
    output logic                      out_valid,
    output logic                      path_found
);
    import gr_pkg::*;

    logic [NODES-1:0]  adj_mem [NODES];
    logic [NODE_W-1:0] stack_mem [NODES];

    logic [NODES-1:0]  row_vld_reg;
    logic [NODES-1:0]  row_vld_next;
    logic [NODES-1:0]  adj_row_reg;
    logic              adj_vld_reg;
    logic [NODE_W-1:0] stack_out_reg;
    logic [NODE_W-1:0] src_reg;
    logic [NODE_W-1:0] dst_reg;
    logic [NODES-1:0]  visited_reg;
    logic [NODES-1:0]  visited_next;
    logic [NODES-1:0]  pend_reg;
    logic [NODES-1:0]  pend_next;
    logic [SP_W-1:0]   sp_reg;
    logic [SP_W-1:0]   sp_next;
    logic              res_vld_reg;
    logic              res_vld_next;
    logic              res_val_reg;

    logic [NODE_W-1:0] rd_addr;
    logic [NODES-1:0]  row_eff;
    logic [NODES-1:0]  cand;
    logic [NODES-1:0]  low_bit;
    logic [NODE_W-1:0] low_idx;
    logic [SP_W-1:0]   sp_dec;

    // row read address: new item or popped vertex
    assign rd_addr = cmd.adj_rd_in ? src_node : stack_out_reg;

    // a row never written since the last clear reads as empty
    assign row_eff = adj_vld_reg ? adj_row_reg : '0;
    assign cand    = row_eff & ~visited_reg;

    // lowest pending neighbour
    assign low_bit = pend_reg & (~pend_reg + NODES'(1));
    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < NODES; i++)
        begin
            if (low_bit[i])
            begin
                low_idx = low_idx | NODE_W'(i);
            end
        end
    end

    assign sp_dec = sp_reg - SP_W'(1);

    // adjacency memory
    always_ff @(posedge clk)
    begin
        if (cmd.adj_rd_in || cmd.adj_rd_stk)
        begin
            adj_row_reg <= adj_mem[rd_addr];
            adj_vld_reg <= row_vld_reg[rd_addr];
        end
        if (cmd.adj_wr)
        begin
            adj_mem[src_reg] <= row_eff | (NODES'(1) << dst_reg);
        end
    end

    // search stack memory
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[sp_reg[NODE_W-1:0]] <= low_idx;
        end
        if (cmd.pop)
        begin
            stack_out_reg <= stack_mem[sp_dec[NODE_W-1:0]];
        end
    end

    // item capture and search vectors
    always_comb
    begin
        visited_next = visited_reg;
        pend_next    = pend_reg;
        if (cmd.q_init)
        begin
            visited_next = NODES'(1) << src_node;
        end
        else if (cmd.expand)
        begin
            visited_next = visited_reg | cand;
            pend_next    = cand;
        end
        else if (cmd.push)
        begin
            pend_next = pend_reg & ~low_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            src_reg <= src_node;
            dst_reg <= dst_node;
        end
        visited_reg <= visited_next;
        pend_reg    <= pend_next;
        if (cmd.res_load)
        begin
            res_val_reg <= cmd.res_value;
        end
    end

    // control registers: row valid bits, stack pointer, result valid
    always_comb
    begin
        row_vld_next = row_vld_reg;
        if (cmd.clr_graph)
        begin
            row_vld_next = '0;
        end
        else if (cmd.adj_wr)
        begin
            row_vld_next = row_vld_reg | (NODES'(1) << src_reg);
        end

        sp_next = sp_reg;
        if (cmd.q_init)
        begin
            sp_next = '0;
        end
        else if (cmd.push)
        begin
            sp_next = sp_reg + SP_W'(1);
        end
        else if (cmd.pop)
        begin
            sp_next = sp_dec;
        end

        res_vld_next = res_vld_reg;
        if (cmd.res_load)
        begin
            res_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            sp_reg      <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            row_vld_reg <= row_vld_next;
            sp_reg      <= sp_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // status to the controller
    assign sts.src_eq_dst = (src_node == dst_node);
    assign sts.hit        = cand[dst_reg];
    assign sts.pend_empty = (pend_reg == '0);
    assign sts.sp_zero    = (sp_reg == '0);
    assign sts.sp_full    = (sp_reg == SP_W'(NODES));
    assign sts.slot_free  = !res_vld_reg || !out_stall;

    assign out_valid  = res_vld_reg;
    assign path_found = res_val_reg;

endmodule

>>> hw/rtl/graph_reachability.sv
// ----------------------------------------------------------------------------
// graph_reachability: directed graph store with reachability queries
// Holds a 64-vertex directed graph, empty after reset. Each item is one
// command: add edge (one row read, then one row write), clear graph (all
// rows dropped at once through per-row valid bits) or query, which gives
// one path_found item. A query with equal source and destination goes
// straight to the result state, its answer loaded there once the output
// register is free; otherwise it runs a depth-first search on a stack
// memory: every visited vertex costs one pop, one row read and one expand
// step, and every newly found neighbour one push step; row reads go through
// the single read port of the adjacency memory. A new item is taken once
// the previous one has finished, while its result may still wait in the
// output register.
// ----------------------------------------------------------------------------
module graph_reachability
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                command,
    input  logic [gr_pkg::NODE_W-1:0] src_node,
    input  logic [gr_pkg::NODE_W-1:0] dst_node,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      path_found
);
    import gr_pkg::*;

    gr_cmd_t cmd;
    gr_sts_t sts;

    // sequencer
    gr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // storage and search datapath
    gr_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_node   (src_node),
        .dst_node   (dst_node),
        .cmd        (cmd),
        .sts        (sts),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .path_found (path_found)
    );

`ifndef SYNTHESIS
    // result register is never overwritten while a result waits stalled
    a_res_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> sts.slot_free)
        else $error("result loaded over a stalled result");

    // no pop from an empty stack
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !sts.sp_zero)
        else $error("pop from empty search stack");

    // each vertex pushed at most once, so the stack never overflows
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !sts.sp_full)
        else $error("push onto full search stack");

    // a query start always reads the source row in the same cycle
    a_init_reads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.q_init |-> cmd.adj_rd_in && cmd.latch_in)
        else $error("search started without source row read");
`endif

endmodule

>>> test/graph_reachability_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_reachability_test: self-checking bench of the reachability engine
// Builds directed graphs through add-edge and clear items, asks reachability
// queries and checks every path_found item against a local depth-first
// search over a shadow copy of the adjacency matrix. Both handshake sides
// idle at random, with quiet stretches, a long output hold-off and a pause
// of the sender until all answers are back.
// ----------------------------------------------------------------------------
module graph_reachability_test;

    import gr_pkg::*;

    // command code with no function in the block
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         HALF_PERIOD = 5;
    localparam int         HOLD_CYCLES = 600;
    localparam int         RANDOM_ITEMS = 660;
    localparam int         SETTLE_CYCLES = 300;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        command = CMD_ADD;
    logic [NODE_W-1:0] src_node = '0;
    logic [NODE_W-1:0] dst_node = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              path_found;

    // shadow of the graph and the answers still owed by the block
    logic [NODES-1:0]  graph_rows [NODES];
    logic              pending_answers [$];

    // idling control shared by both sides
    bit                quiet = 1'b0;
    int                hold_requests = 0;
    int                hold_served = 0;
    int                hold_left = 0;

    int                error_count = 0;
    int                queries_sent = 0;
    int                edges_sent = 0;
    int                clears_sent = 0;
    int                answers_checked = 0;
    int                input_stall_cycles = 0;

    graph_reachability uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .src_node   (src_node),
        .dst_node   (dst_node),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .path_found (path_found)
    );

    always #HALF_PERIOD clk = ~clk;

    // depth-first search over the shadow graph, neighbours pushed lowest first
    function automatic logic reach_predict(logic [NODE_W-1:0] from_v, logic [NODE_W-1:0] to_v);
        logic [NODES-1:0]  seen;
        logic [NODE_W-1:0] walk_stack [NODES];
        int                depth;
        logic [NODE_W-1:0] v;
        if (from_v == to_v)
            return 1'b1;
        seen = '0;
        seen[from_v] = 1'b1;
        walk_stack[0] = from_v;
        depth = 1;
        while (depth > 0)
        begin
            depth--;
            v = walk_stack[depth];
            for (int w = 0; w < NODES; w++)
            begin
                if (graph_rows[v][w] && !seen[w])
                begin
                    if (w == to_v)
                        return 1'b1;
                    seen[w] = 1'b1;
                    walk_stack[depth] = NODE_W'(w);
                    depth++;
                end
            end
        end
        return 1'b0;
    endfunction

    // update the shadow graph, or queue the expected answer, for one accepted item
    task automatic apply_item(logic [1:0] c, logic [NODE_W-1:0] s, logic [NODE_W-1:0] d);
        case (c)
            CMD_ADD:
            begin
                graph_rows[s][d] = 1'b1;
                edges_sent++;
            end
            CMD_QUERY:
            begin
                pending_answers.insert(pending_answers.size(), reach_predict(s, d));
                queries_sent++;
            end
            CMD_CLEAR:
            begin
                foreach (graph_rows[r])
                    graph_rows[r] = '0;
                clears_sent++;
            end
            default:
                ;
        endcase
    endtask

    // offer one item, with a random gap first, and wait for its acceptance
    task automatic send_item(logic [1:0] c, logic [NODE_W-1:0] s, logic [NODE_W-1:0] d);
        while (!quiet && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= c;
        src_node <= s;
        dst_node <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_item(c, s, d);
    endtask

    // sender holds back until every owed answer has come
    task automatic wait_all_answered();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // extremes of the fields, each command and the corner cases by hand
    task automatic test_directed();
        send_item(CMD_QUERY,  6'd0,  6'd0);
        send_item(CMD_QUERY,  6'd0,  6'd63);
        send_item(CMD_QUERY,  6'd63, 6'd63);
        send_item(CMD_ADD,    6'd0,  6'd63);
        send_item(CMD_QUERY,  6'd0,  6'd63);
        send_item(CMD_QUERY,  6'd63, 6'd0);
        send_item(CMD_ADD,    6'd63, 6'd63);
        send_item(CMD_QUERY,  6'd63, 6'd0);
        send_item(CMD_ADD,    6'd63, 6'd21);
        send_item(CMD_ADD,    6'd21, 6'd42);
        send_item(CMD_QUERY,  6'd0,  6'd42);
        send_item(CMD_UNUSED, 6'd42, 6'd0);
        send_item(CMD_QUERY,  6'd42, 6'd0);
        send_item(CMD_ADD,    6'd42, 6'd0);
        send_item(CMD_QUERY,  6'd21, 6'd0);
        send_item(CMD_CLEAR,  6'd63, 6'd63);
        send_item(CMD_QUERY,  6'd0,  6'd63);
        send_item(CMD_QUERY,  6'd21, 6'd21);
        send_item(CMD_UNUSED, 6'd63, 6'd63);
        send_item(CMD_ADD,    6'd42, 6'd21);
        send_item(CMD_QUERY,  6'd42, 6'd21);
        send_item(CMD_QUERY,  6'd21, 6'd42);
    endtask

    // deepest search: a chain through every vertex, then a wide fan-out
    task automatic test_long_searches();
        quiet = 1'b1;
        send_item(CMD_CLEAR, 6'd0, 6'd0);
        for (int k = NODES - 2; k >= 0; k--)
            send_item(CMD_ADD, NODE_W'(k), NODE_W'(k + 1));
        send_item(CMD_QUERY, 6'd0,  6'd63);
        send_item(CMD_QUERY, 6'd63, 6'd0);
        send_item(CMD_QUERY, 6'd1,  6'd0);
        quiet = 1'b0;
        send_item(CMD_QUERY, 6'd32, 6'd63);
        // fan-out from vertex 0 that misses vertex 63
        send_item(CMD_CLEAR, 6'd0, 6'd0);
        for (int k = 1; k < NODES - 1; k++)
            send_item(CMD_ADD, 6'd0, NODE_W'(k));
        send_item(CMD_QUERY, 6'd0, 6'd63);
        send_item(CMD_QUERY, 6'd0, 6'd62);
        send_item(CMD_QUERY, 6'd5, 6'd0);
    endtask

    // receiver holds off for a long time while queries keep coming
    task automatic test_output_holdoff();
        send_item(CMD_CLEAR, 6'd0, 6'd0);
        for (int k = 0; k < 8; k++)
            send_item(CMD_ADD, NODE_W'(k * 7), NODE_W'(k * 7 + 7));
        wait_all_answered();
        hold_requests <= hold_requests + 1;
        quiet = 1'b1;
        for (int k = 0; k < 12; k++)
            send_item(CMD_QUERY, NODE_W'($urandom_range(7) * 7), NODE_W'($urandom_range(8) * 7));
        quiet = 1'b0;
    endtask

    // sender stops until the block has answered everything, then resumes
    task automatic test_sender_pause();
        for (int k = 0; k < 4; k++)
            send_item(CMD_QUERY, NODE_W'($urandom), 6'd56);
        wait_all_answered();
        for (int k = 0; k < 4; k++)
            send_item(CMD_QUERY, 6'd0, NODE_W'($urandom));
    endtask

    // random graphs: a small vertex set with random edges, then queries on it
    task automatic test_random_graphs();
        logic [NODE_W-1:0] vertex_set [20];
        int                set_size;
        int                edge_count;
        int                query_count;
        int                done;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            quiet = (done >= 250 && done < 400);
            if ($urandom_range(9) < 7)
            begin
                send_item(CMD_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
                done++;
            end
            set_size = ($urandom_range(9) == 0) ? 20 : $urandom_range(12, 2);
            for (int k = 0; k < set_size; k++)
                vertex_set[k] = NODE_W'($urandom);
            edge_count = $urandom_range(2 * set_size, 1);
            for (int k = 0; k < edge_count; k++)
            begin
                if ($urandom_range(19) == 0)
                    send_item(CMD_ADD, NODE_W'($urandom), NODE_W'($urandom));
                else
                    send_item(CMD_ADD, vertex_set[$urandom_range(set_size - 1)],
                              vertex_set[$urandom_range(set_size - 1)]);
                done++;
                if ($urandom_range(29) == 0)
                    send_item(CMD_UNUSED, NODE_W'($urandom), NODE_W'($urandom));
            end
            query_count = $urandom_range(8, 2);
            for (int k = 0; k < query_count; k++)
            begin
                if ($urandom_range(4) == 0)
                    send_item(CMD_QUERY, NODE_W'($urandom), NODE_W'($urandom));
                else
                    send_item(CMD_QUERY, vertex_set[$urandom_range(set_size - 1)],
                              vertex_set[$urandom_range(set_size - 1)]);
                done++;
            end
        end
        quiet = 1'b0;
    endtask

    // receiver stall: random, quiet, or a long counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 20);
    end

    // check each path_found item against the oldest owed answer
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_stall)
            input_stall_cycles++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: path_found %0b with no query outstanding", $time, path_found);
                error_count++;
            end
            else
            begin
                if (path_found !== pending_answers[0])
                begin
                    $display("%0t: path_found expected %0b actual %0b", $time,
                             pending_answers[0], path_found);
                    error_count++;
                end
                void'(pending_answers.pop_front());
                answers_checked++;
            end
        end
    end

    // run-time limit
    initial
    begin
        #10ms;
        $display("%0t: timeout with %0d answers outstanding", $time, pending_answers.size());
        $display("== FAIL ==");
        $finish;
    end

    // test sequence
    initial
    begin
        foreach (graph_rows[r])
            graph_rows[r] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_long_searches();
        test_output_holdoff();
        test_sender_pause();
        test_random_graphs();
        wait_all_answered();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d edge loads, %0d clears and %0d queries, %0d answers checked",
                 edges_sent, clears_sent, queries_sent, answers_checked);
        $display("input held back for %0d cycles by the block", input_stall_cycles);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/gr_pkg.sv
hw/rtl/gr_ctrl.sv
hw/rtl/gr_datapath.sv
hw/rtl/graph_reachability.sv
test/graph_reachability_test.sv
